FILE: rtl/core/sgr_pkg.sv
// Shared constants and types for the stream group reverser.
`default_nettype none

package sgr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int GS_W      = 5;
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = 1;
    localparam int ADDR_W    = BANK_W + IDX_W;
    localparam int Q_DEPTH   = 2;

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } sgr_wr_t;

    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  cnt;
        logic              rev;
        logic              fin;
    } sgr_grp_t;

    typedef struct packed {
        logic              en;
        logic              bank;
    } sgr_rel_t;

endpackage

`default_nettype wire

FILE: rtl/core/stream_group_reverser_core.sv
// Closed groups are queued, then the back end reads them out through an output register.
// Throughput: one element per cycle out while m_tready is high.
// A full group comes out reversed, a short final group in arrival order.
// Ready drops while the bank to be filled next is still draining.
// Reset (aresetn low, synchronous) empties banks and queue and sets group size to 2.
`default_nettype none

module stream_group_reverser_core
    import sgr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [GS_W-1:0]   cfg_wr_data,    // group_size
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,        // [31:0] value
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,        // [31:0] out_value
    output logic                   m_tlast
);

    sgr_wr_t  wr;
    sgr_rel_t rel;
    sgr_grp_t push_grp;
    sgr_grp_t head_grp;
    logic     push;
    logic     pop;
    logic     head_valid;

    sgr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .rel         (rel),
        .wr          (wr),
        .push        (push),
        .push_grp    (push_grp)
    );

    sgr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_grp   (push_grp),
        .pop        (pop),
        .head_valid (head_valid),
        .head_grp   (head_grp)
    );

    sgr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .head_valid (head_valid),
        .head_grp   (head_grp),
        .pop        (pop),
        .rel        (rel),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/sgr_front.sv
// Front end: accepts elements, fills a buffer bank and closes groups.
`default_nettype none

module sgr_front
    import sgr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [GS_W-1:0]   cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    input  wire sgr_rel_t          rel,
    output sgr_wr_t                wr,
    output logic                   push,
    output sgr_grp_t               push_grp
);

    logic [GS_W-1:0]      gs_reg;
    logic [IDX_W-1:0]     fill_reg, fill_next;
    logic                 wbank_reg, wbank_next;
    logic [NUM_BANKS-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]     k_eff;
    logic [CNT_W-1:0]     n_cnt;
    logic                 accept;
    logic                 full_grp;
    logic                 close;

    always_comb begin
        if (gs_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (CNT_W'(gs_reg) > CNT_W'(MAX_GROUP)) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = CNT_W'(gs_reg);
        end
    end

    assign s_tready = !busy_reg[wbank_reg];
    assign accept   = s_tvalid && s_tready;
    assign n_cnt    = CNT_W'(fill_reg) + CNT_W'(1);
    assign full_grp = n_cnt >= k_eff;
    assign close    = accept && (full_grp || s_tlast);

    assign wr.en   = accept;
    assign wr.addr = {wbank_reg, fill_reg};
    assign wr.data = s_tdata;

    assign push          = close;
    assign push_grp.bank = wbank_reg;
    assign push_grp.cnt  = n_cnt;
    assign push_grp.rev  = full_grp;
    assign push_grp.fin  = s_tlast;

    always_comb begin
        fill_next  = fill_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (close) begin
            fill_next            = '0;
            wbank_next           = !wbank_reg;
            busy_next[wbank_reg] = 1'b1;
        end else if (accept) begin
            fill_next = fill_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_reg    <= GS_RESET;
            fill_reg  <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                gs_reg <= cfg_wr_data;
            end
            fill_reg  <= fill_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    a_close_marks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        close |=> busy_reg[$past(wbank_reg)])
        else $error("closed bank not marked busy");

    a_release_busy_only: assert property (@(posedge aclk) disable iff (!aresetn)
        rel.en |-> busy_reg[rel.bank])
        else $error("release of a bank that is not busy");

endmodule

`default_nettype wire

FILE: rtl/core/sgr_queue.sv
// Two-entry queue of closed group descriptors between front and back.
`default_nettype none

module sgr_queue
    import sgr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire sgr_grp_t push_grp,
    input  wire logic     pop,
    output logic          head_valid,
    output sgr_grp_t      head_grp
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int QC_W  = $clog2(Q_DEPTH + 1);

    sgr_grp_t         entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [QC_W-1:0]  count_reg, count_next;
    logic             do_pop;

    assign head_valid = count_reg != '0;
    assign head_grp   = entry_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QC_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != QC_W'(Q_DEPTH)) || do_pop)
        else $error("group queue overflow");

endmodule

`default_nettype wire

FILE: rtl/core/sgr_back.sv
// Back end: holds the group buffer and drains closed groups in order.
`default_nettype none

module sgr_back
    import sgr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sgr_wr_t           wr,
    input  wire logic              head_valid,
    input  wire sgr_grp_t          head_grp,
    output logic                   pop,
    output sgr_rel_t               rel,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    logic [DATA_W-1:0] mem [NUM_BANKS * MAX_GROUP];

    logic              active_reg;
    sgr_grp_t          grp_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              m_valid_reg;
    logic              m_last_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              out_free;
    logic              issue;
    logic              last_issue;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  addr_full;
    logic [IDX_W-1:0]  rd_idx;

    assign out_free   = !m_valid_reg || m_tready;
    assign issue      = active_reg && out_free;
    assign cnt_m1     = grp_reg.cnt - CNT_W'(1);
    assign last_issue = issue && (idx_reg == cnt_m1);
    assign pop        = head_valid && (!active_reg || last_issue);
    assign addr_full  = grp_reg.rev ? (cnt_m1 - idx_reg) : idx_reg;
    assign rd_idx     = addr_full[IDX_W-1:0];

    assign rel.en   = last_issue;
    assign rel.bank = grp_reg.bank;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (issue) begin
            m_data_reg <= mem[{grp_reg.bank, rd_idx}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            grp_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (pop) begin
                active_reg <= 1'b1;
                grp_reg    <= head_grp;
                idx_reg    <= '0;
            end else if (last_issue) begin
                active_reg <= 1'b0;
            end else if (issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (issue) begin
                m_valid_reg <= 1'b1;
                m_last_reg  <= grp_reg.fin && (idx_reg == cnt_m1);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (idx_reg < grp_reg.cnt) && (grp_reg.cnt != '0))
        else $error("drain index outside group");

    a_issue_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> m_valid_reg)
        else $error("issued element not presented");

endmodule

`default_nettype wire

FILE: tb/stream_group_reverser_core_tb.sv
// Self-checking testbench for stream_group_reverser_core: random stalls, group sweep, reorder check.
`timescale 1ns / 1ps

module stream_group_reverser_core_tb
    import sgr_pkg::*;
;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 132;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     fin;
    } element_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } beat_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [GS_W-1:0]   cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata     = '0;    // [31:0] value
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [DATA_W-1:0] m_tdata;             // [31:0] out_value
    logic              m_tlast;

    element_t element_queue[$];
    beat_t    expected_beats[$];

    logic [DATA_W-1:0] group_mem [MAX_GROUP];
    int unsigned       fill_level = 0;
    logic [GS_W-1:0]   size_reg   = GS_RESET;

    int unsigned send_wait;
    int unsigned recv_wait;
    bit          send_burst     = 1'b0;
    bit          recv_burst     = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    stream_group_reverser_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned effective_group(input logic [GS_W-1:0] gs);
        int unsigned k;
        k = 32'(gs);
        if (k == 0) k = 1;
        if (k > MAX_GROUP) k = MAX_GROUP;
        return k;
    endfunction

    function automatic int unsigned gap_draw(input bit burst);
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Buffer one element; emit a full group reversed, a short final group in order.
    task automatic reorder_element(input logic [DATA_W-1:0] value, input logic fin);
        int unsigned k;
        int unsigned n;
        beat_t       beat;
        k = effective_group(size_reg);
        if (fill_level < MAX_GROUP) begin
            group_mem[IDX_W'(fill_level)] = value;
            fill_level++;
        end
        n = fill_level;
        if (n < k && !fin) return;
        for (int unsigned i = 0; i < n; i++) begin
            beat.value = (n >= k) ? group_mem[IDX_W'(n - 1 - i)] : group_mem[IDX_W'(i)];
            beat.last  = fin && (i == n - 1);
            expected_beats = {expected_beats, beat};
        end
        fill_level = 0;
    endtask

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    endtask

    task automatic push_element(input logic [DATA_W-1:0] value, input logic fin);
        element_t e;
        e.value = value;
        e.fin   = fin;
        element_queue = {element_queue, e};
    endtask

    // Wait until every transfer is done and the pipeline has drained.
    task automatic settle();
        while (element_queue.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_group_size(input logic [GS_W-1:0] gs);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gs;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        size_reg = gs;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : driver
        element_t e;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else if (s_tvalid && s_tready) begin
            reorder_element(s_tdata, s_tlast);
            if (send_wait == 0 && element_queue.size() != 0) begin
                e = element_queue.pop_front();
                s_tdata   <= e.value;
                s_tlast   <= e.fin;
                send_wait <= gap_draw(send_burst);
                if ($urandom_range(0, 15) == 0) send_burst <= !send_burst;
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (!s_tvalid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (element_queue.size() != 0) begin
                e = element_queue.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= e.value;
                s_tlast   <= e.fin;
                send_wait <= gap_draw(send_burst);
                if ($urandom_range(0, 15) == 0) send_burst <= !send_burst;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        beat_t       want;
        int unsigned g;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata, '0);
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.value) report_mismatch("out_value", m_tdata, want.value);
                if (m_tlast !== want.last)
                    report_mismatch("out_last", DATA_W'(m_tlast), DATA_W'(want.last));
            end
            g = gap_draw(recv_burst);
            if ($urandom_range(0, 15) == 0) recv_burst <= !recv_burst;
            if (g != 0) begin
                m_tready  <= 1'b0;
                recv_wait <= g - 1;
            end
        end else if (!m_tready) begin
            if (recv_wait != 0) recv_wait <= recv_wait - 1;
            else m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned     sent;
        int unsigned     phase;
        int unsigned     k;
        int unsigned     lists;
        int unsigned     len;
        bit              open_end;
        logic [GS_W-1:0] gs;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset group size: extremes, a short final group, then a final element on a full group.
        push_element(32'h8000_0000, 1'b0);
        push_element(32'h7FFF_FFFF, 1'b0);
        push_element(32'h0000_0000, 1'b0);
        push_element(32'hFFFF_FFFF, 1'b0);
        push_element(32'h0000_0001, 1'b1);
        push_element(32'h1234_5678, 1'b0);
        push_element(32'h9ABC_DEF0, 1'b1);

        write_group_size(GS_W'(1));
        push_element(32'hAAAA_5555, 1'b0);
        push_element(32'h5555_AAAA, 1'b0);
        push_element(32'h0F0F_F0F0, 1'b1);

        write_group_size(GS_W'(0));
        push_element(32'hDEAD_BEEF, 1'b0);
        push_element(32'h0000_00FF, 1'b1);

        write_group_size(GS_W'(31));
        push_element(32'h1111_1111, 1'b0);
        push_element(32'h2222_2222, 1'b0);
        push_element(32'h3333_3333, 1'b1);

        // Lower the group size below the fill level mid-group.
        write_group_size(GS_W'(5));
        push_element(32'h0000_000A, 1'b0);
        push_element(32'h0000_000B, 1'b0);
        push_element(32'h0000_000C, 1'b0);
        write_group_size(GS_W'(2));
        push_element(32'h0000_000D, 1'b0);
        push_element(32'h0000_000E, 1'b1);

        write_group_size(GS_W'(3));
        push_element(32'hCAFE_0001, 1'b0);
        push_element(32'hCAFE_0002, 1'b0);
        push_element(32'hCAFE_0003, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: gs = GS_W'(16);
                1: gs = GS_W'(1);
                2: gs = GS_W'(31);
                3: gs = GS_W'(0);
                4: gs = GS_W'(17);
                5: gs = GS_W'(2);
                default: gs = GS_W'($urandom_range(0, 31));
            endcase
            write_group_size(gs);
            k     = effective_group(gs);
            lists = $urandom_range(1, 3);
            for (int unsigned l = 0; l < lists && sent < RANDOM_ITEMS; l++) begin
                len      = $urandom_range(1, 2 * k + 1);
                if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
                open_end = (l == lists - 1) && ($urandom_range(0, 3) == 0);
                for (int unsigned j = 0; j < len; j++) begin
                    push_element(pick_value(), (j == len - 1) && !open_end);
                    sent++;
                end
            end
            phase++;
        end
        push_element(pick_value(), 1'b1);

        while (element_queue.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sgr_pkg.sv
rtl/core/sgr_front.sv
rtl/core/sgr_queue.sv
rtl/core/sgr_back.sv
rtl/core/stream_group_reverser_core.sv
tb/stream_group_reverser_core_tb.sv
